// ===== hdl/sbus_channel_decoder_top_defines.svh =====
// assertion macros for the s.bus channel decoder
`ifndef SBUS_CHANNEL_DECODER_TOP_DEFINES_SVH
`define SBUS_CHANNEL_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define SBCD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sbcd assertion failed");

// condition must never be seen at a clock edge out of reset
`define SBCD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sbcd forbidden condition seen");

`else

`define SBCD_ASSERT(label, clk, rst, prop)
`define SBCD_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== hdl/sbcd_pkg.sv =====
package sbcd_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int RAW_W    = 11;
   localparam int SCALED_W = 10;
   localparam int LEVEL_W  = 3;
   localparam int CHAN_W   = 5;
   localparam int ACC_W    = 18;
   localparam int POS_W    = 5;
   localparam int PEND_W   = 5;
   localparam int PROD_W   = 21;

   // frame positions
   localparam logic [POS_W-1:0] POS_FIRST     = 5'd1;
   localparam logic [POS_W-1:0] POS_LAST_DATA = 5'd22;
   localparam logic [POS_W-1:0] POS_FLAGS     = 5'd23;
   localparam logic [POS_W-1:0] POS_IDLE      = 5'd24;

   // channel index of the flags item
   localparam logic [CHAN_W-1:0] FLAGS_INDEX = 5'd16;

   // scaling: raw * 1000 / 2048
   localparam logic [SCALED_W-1:0] SCALE_MULT  = 10'd1000;
   localparam int                  SCALE_SHIFT = 11;

   // five-band level classes
   localparam logic [LEVEL_W-1:0] LEVEL_LOW      = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID_LOW  = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_CENTER   = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_MID_HIGH = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH     = 3'd4;

   // flag byte bits
   localparam int FLAG_BIT_DIGITAL_ONE = 0;
   localparam int FLAG_BIT_DIGITAL_TWO = 1;
   localparam int FLAG_BIT_FRAME_LOST  = 2;

   // queue between unpacker and output stages
   localparam int QUEUE_DEPTH = 4;

   // csr map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_EDGE_LOW      = 2'd0;
   localparam logic [1:0] REG_EDGE_MID_LOW  = 2'd1;
   localparam logic [1:0] REG_EDGE_MID_HIGH = 2'd2;
   localparam logic [1:0] REG_EDGE_HIGH     = 2'd3;

   localparam logic [RAW_W-1:0] EDGE_LOW_RESET      = 11'd360;
   localparam logic [RAW_W-1:0] EDGE_MID_LOW_RESET  = 11'd1016;
   localparam logic [RAW_W-1:0] EDGE_MID_HIGH_RESET = 11'd1032;
   localparam logic [RAW_W-1:0] EDGE_HIGH_RESET     = 11'd1688;

   // one unpacked item on its way to the output stages
   typedef struct packed {
      logic [CHAN_W-1:0] chan_index;
      logic [RAW_W-1:0]  raw;
      logic              frame_lost;
      logic              digital_one;
      logic              digital_two;
      logic              last;
   } entry_type;

   // level thresholds
   typedef struct packed {
      logic [RAW_W-1:0] low;
      logic [RAW_W-1:0] mid_low;
      logic [RAW_W-1:0] mid_high;
      logic [RAW_W-1:0] high;
   } edges_type;

endpackage

// ===== hdl/sbcd_front.sv =====
module sbcd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   input  logic [sbcd_pkg::BYTE_W-1:0]   byte_data,
   input  logic                          byte_start,
   output logic                          push_valid,
   output sbcd_pkg::entry_type           push_entry
);
   import sbcd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   logic [ACC_W-1:0]  acc_merged;
   logic [PEND_W-1:0] pend_added;
   logic              in_data;

   // merge the new byte above the pending bits
   assign acc_merged = acc_ff | ({{(ACC_W-BYTE_W){1'b0}}, byte_data} << pend_ff);
   assign pend_added = pend_ff + PEND_W'(BYTE_W);
   assign in_data    = (pos_ff >= POS_FIRST) && (pos_ff <= POS_LAST_DATA);

   // frame sequencing and unpacking
   always_comb begin
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      pend_in    = pend_ff;
      chan_in    = chan_ff;
      push_valid = 1'b0;
      push_entry = '0;
      if (byte_valid) begin
         if (byte_start) begin
            pos_in  = POS_FIRST;
            acc_in  = '0;
            pend_in = '0;
            chan_in = '0;
         end else if (in_data) begin
            pos_in = pos_ff + 1'b1;
            if (pend_added >= PEND_W'(RAW_W)) begin
               acc_in                = acc_merged >> RAW_W;
               pend_in               = pend_added - PEND_W'(RAW_W);
               chan_in               = chan_ff + 1'b1;
               push_valid            = 1'b1;
               push_entry.chan_index = chan_ff;
               push_entry.raw        = acc_merged[RAW_W-1:0];
            end else begin
               acc_in  = acc_merged;
               pend_in = pend_added;
            end
         end else if (pos_ff == POS_FLAGS) begin
            pos_in                 = POS_IDLE;
            push_valid             = 1'b1;
            push_entry.chan_index  = FLAGS_INDEX;
            push_entry.frame_lost  = byte_data[FLAG_BIT_FRAME_LOST];
            push_entry.digital_one = byte_data[FLAG_BIT_DIGITAL_ONE];
            push_entry.digital_two = byte_data[FLAG_BIT_DIGITAL_TWO];
            push_entry.last        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_IDLE;
         acc_ff  <= '0;
         pend_ff <= '0;
         chan_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         chan_ff <= chan_in;
      end
   end

endmodule

// ===== hdl/sbcd_queue.sv =====
module sbcd_queue #(
   parameter int Depth = sbcd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sbcd_pkg::entry_type push_entry,
   output logic                full,
   output logic                head_valid,
   output sbcd_pkg::entry_type head_entry,
   input  logic                pop
);
   import sbcd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/sbcd_back.sv =====
module sbcd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  sbcd_pkg::edges_type             edges,
   input  logic                            head_valid,
   input  sbcd_pkg::entry_type             head_entry,
   output logic                            pop,
   output logic                            out_valid,
   input  logic                            out_ready,
   output sbcd_pkg::entry_type             out_entry,
   output logic [sbcd_pkg::SCALED_W-1:0]   out_scaled,
   output logic [sbcd_pkg::LEVEL_W-1:0]    out_level
);
   import sbcd_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   entry_type           s1_entry_ff;
   logic [PROD_W-1:0]   s1_prod_ff;
   logic [LEVEL_W-1:0]  s1_level_ff;
   logic                out_valid_ff, out_valid_in;
   entry_type           out_entry_ff;
   logic [SCALED_W-1:0] out_scaled_ff;
   logic [LEVEL_W-1:0]  out_level_ff;

   logic                out_advance, s1_advance;
   logic [LEVEL_W-1:0]  head_level;

   assign out_advance = !out_valid_ff || out_ready;
   assign s1_advance  = !s1_valid_ff || out_advance;
   assign pop         = s1_advance && head_valid;

   // five-band class, first threshold that holds wins; flags item is level 0
   always_comb begin
      if (head_entry.last || head_entry.raw < edges.low) begin
         head_level = LEVEL_LOW;
      end else if (head_entry.raw < edges.mid_low) begin
         head_level = LEVEL_MID_LOW;
      end else if (head_entry.raw < edges.mid_high) begin
         head_level = LEVEL_CENTER;
      end else if (head_entry.raw < edges.high) begin
         head_level = LEVEL_MID_HIGH;
      end else begin
         head_level = LEVEL_HIGH;
      end
   end

   // stage valids
   always_comb begin
      s1_valid_in  = s1_advance ? head_valid : s1_valid_ff;
      out_valid_in = out_advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_entry_ff <= head_entry;
         s1_prod_ff  <= PROD_W'(head_entry.raw) * PROD_W'(SCALE_MULT);
         s1_level_ff <= head_level;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_advance) begin
         out_entry_ff  <= s1_entry_ff;
         out_scaled_ff <= s1_prod_ff[SCALE_SHIFT +: SCALED_W];
         out_level_ff  <= s1_level_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_entry  = out_entry_ff;
   assign out_scaled = out_scaled_ff;
   assign out_level  = out_level_ff;

endmodule

// ===== hdl/sbus_channel_decoder_top.sv =====
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | tdata data_byte, tuser frame_start
// rsp      | out | rsp_tvalid/rsp_tready  | tdata values and flags, tuser index, tlast
// csr      | in  | apb, pready tied high  | four 11-bit level thresholds
//
// one byte per cycle while the queue is not full; a result passes through the
// queue entry, the multiply stage and the output register on its way to rsp.
// the queue lets bytes keep coming while rsp is stalled, until it fills;
// req_tready drops only when the queue is full.
// reset is synchronous, active high; thresholds return to their defaults.
`include "sbus_channel_decoder_top_defines.svh"

module sbus_channel_decoder_top #(
   parameter int QueueDepth = sbcd_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // req
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic [0:0]                        req_tuser,  // [0] frame_start
   // rsp
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [10:0] raw_value, [20:11] scaled_value, [23:21] level, [24] frame_lost,
   // [25] digital_one, [26] digital_two, [31:27] zero
   output logic [31:0]                       rsp_tdata,
   output logic [4:0]                        rsp_tuser,  // [4:0] channel_index
   output logic                              rsp_tlast,
   // csr
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sbcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sbcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sbcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import sbcd_pkg::*;

   edges_type           edges_ff, edges_in;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [RAW_W-1:0]    csr_read_value;

   logic                byte_valid;
   logic                push_valid;
   entry_type           push_entry;
   logic                queue_full;
   logic                head_valid;
   entry_type           head_entry;
   logic                pop;
   entry_type           out_entry;
   logic [SCALED_W-1:0] out_scaled;
   logic [LEVEL_W-1:0]  out_level;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      edges_in = edges_ff;
      if (csr_write) begin
         case (csr_index)
            REG_EDGE_LOW:      edges_in.low      = csr_pwdata[RAW_W-1:0];
            REG_EDGE_MID_LOW:  edges_in.mid_low  = csr_pwdata[RAW_W-1:0];
            REG_EDGE_MID_HIGH: edges_in.mid_high = csr_pwdata[RAW_W-1:0];
            REG_EDGE_HIGH:     edges_in.high     = csr_pwdata[RAW_W-1:0];
            default:           edges_in = edges_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_EDGE_LOW:      csr_read_value = edges_ff.low;
         REG_EDGE_MID_LOW:  csr_read_value = edges_ff.mid_low;
         REG_EDGE_MID_HIGH: csr_read_value = edges_ff.mid_high;
         REG_EDGE_HIGH:     csr_read_value = edges_ff.high;
         default:           csr_read_value = '0;
      endcase
   end
   assign csr_prdata = CSR_DATA_W'(csr_read_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff.low      <= EDGE_LOW_RESET;
         edges_ff.mid_low  <= EDGE_MID_LOW_RESET;
         edges_ff.mid_high <= EDGE_MID_HIGH_RESET;
         edges_ff.high     <= EDGE_HIGH_RESET;
      end else begin
         edges_ff <= edges_in;
      end
   end

   // byte intake
   assign req_tready = !queue_full;
   assign byte_valid = req_tvalid && req_tready;

   sbcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .byte_start (req_tuser[0]),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   sbcd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   sbcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .edges      (edges_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_entry  (out_entry),
      .out_scaled (out_scaled),
      .out_level  (out_level)
   );

   // result packing
   assign rsp_tdata = {5'd0, out_entry.digital_two, out_entry.digital_one,
                       out_entry.frame_lost, out_level, out_scaled, out_entry.raw};
   assign rsp_tuser = out_entry.chan_index;
   assign rsp_tlast = out_entry.last;

   // checks
   `SBCD_ASSERT(a_last_is_flags, clock, reset, (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == FLAGS_INDEX))
   `SBCD_ASSERT(a_chan_below_flags, clock, reset, (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser[4] == 1'b0))
   `SBCD_ASSERT(a_flags_no_value, clock, reset, (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[23:0] == 24'd0))
   `SBCD_ASSERT_NEVER(a_chan_no_flags, clock, reset, rsp_tvalid && !rsp_tlast && (rsp_tdata[26:24] != 3'd0))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sbcd_pkg::*;

   // one decoded item as it leaves on rsp
   typedef struct packed {
      logic [CHAN_W-1:0]   chan_index;
      logic [RAW_W-1:0]    raw;
      logic [SCALED_W-1:0] scaled;
      logic [LEVEL_W-1:0]  level;
      logic                frame_lost;
      logic                digital_one;
      logic                digital_two;
      logic                last;
      logic [4:0]          pad;
   } channel_result_type;

   localparam logic [RAW_W-1:0] RAW_MAX = 11'd2047;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sbus_channel_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder state mirrored by the testbench
   edges_type            thresholds;
   logic [POS_W-1:0]     frame_pos;
   logic [ACC_W-1:0]     bit_acc;
   logic [PEND_W-1:0]    bits_held;
   logic [CHAN_W-1:0]    chan_count;

   channel_result_type   channel_results_q[$];
   logic [8:0]           pending_bytes_q[$];   // {frame_start, data_byte}

   int  bytes_queued   = 0;
   int  bytes_accepted = 0;
   int  mismatch_count = 0;
   int  send_gap_pct   = 0;
   int  recv_gap_pct   = 0;
   bit  req_accepted   = 1'b0;

   function automatic logic [LEVEL_W-1:0] band_of(input logic [RAW_W-1:0] raw);
      if (raw < thresholds.low) return LEVEL_LOW;
      if (raw < thresholds.mid_low) return LEVEL_MID_LOW;
      if (raw < thresholds.mid_high) return LEVEL_CENTER;
      if (raw < thresholds.high) return LEVEL_MID_HIGH;
      return LEVEL_HIGH;
   endfunction

   // unpack one frame byte and queue the channel or flags item it completes
   task automatic decode_byte(input logic [7:0] data, input logic start);
      channel_result_type  r;
      logic [PROD_W-1:0]   prod;
      r = '0;
      if (start) begin
         frame_pos  = POS_FIRST;
         bit_acc    = '0;
         bits_held  = '0;
         chan_count = '0;
      end else if (frame_pos >= POS_FIRST && frame_pos <= POS_LAST_DATA) begin
         frame_pos = frame_pos + 1'b1;
         bit_acc   = bit_acc | (ACC_W'(data) << bits_held);
         bits_held = bits_held + 5'd8;
         if (bits_held >= 5'd11) begin
            r.raw      = bit_acc[RAW_W-1:0];
            bit_acc    = bit_acc >> RAW_W;
            bits_held  = bits_held - 5'd11;
            r.chan_index = chan_count;
            prod       = PROD_W'(r.raw) * PROD_W'(SCALE_MULT);
            r.scaled   = SCALED_W'(prod >> SCALE_SHIFT);
            r.level    = band_of(r.raw);
            chan_count = chan_count + 1'b1;
            channel_results_q.push_back(r);
         end
      end else if (frame_pos == POS_FLAGS) begin
         frame_pos     = POS_IDLE;
         r.chan_index  = FLAGS_INDEX;
         r.frame_lost  = data[FLAG_BIT_FRAME_LOST];
         r.digital_one = data[FLAG_BIT_DIGITAL_ONE];
         r.digital_two = data[FLAG_BIT_DIGITAL_TWO];
         r.last        = 1'b1;
         channel_results_q.push_back(r);
      end
   endtask

   function automatic string fmt_result(input channel_result_type r);
      return $sformatf("chan %0d raw %0d scaled %0d level %0d lost %b d1 %b d2 %b last %b pad %h",
                       r.chan_index, r.raw, r.scaled, r.level, r.frame_lost,
                       r.digital_one, r.digital_two, r.last, r.pad);
   endfunction

   // sample both channels and csr writes, predict and check
   always @(posedge clock) begin
      channel_result_type got;
      channel_result_type want;
      if (reset) begin
         thresholds.low      = EDGE_LOW_RESET;
         thresholds.mid_low  = EDGE_MID_LOW_RESET;
         thresholds.mid_high = EDGE_MID_HIGH_RESET;
         thresholds.high     = EDGE_HIGH_RESET;
         frame_pos    = POS_IDLE;
         bit_acc      = '0;
         bits_held    = '0;
         chan_count   = '0;
         req_accepted = 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_EDGE_LOW:      thresholds.low      = csr_pwdata[RAW_W-1:0];
               REG_EDGE_MID_LOW:  thresholds.mid_low  = csr_pwdata[RAW_W-1:0];
               REG_EDGE_MID_HIGH: thresholds.mid_high = csr_pwdata[RAW_W-1:0];
               REG_EDGE_HIGH:     thresholds.high     = csr_pwdata[RAW_W-1:0];
               default: ;
            endcase
         end
         req_accepted = req_tvalid && req_tready;
         if (req_accepted) begin
            decode_byte(req_tdata, req_tuser[0]);
            bytes_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.chan_index  = rsp_tuser;
            got.raw         = rsp_tdata[10:0];
            got.scaled      = rsp_tdata[20:11];
            got.level       = rsp_tdata[23:21];
            got.frame_lost  = rsp_tdata[24];
            got.digital_one = rsp_tdata[25];
            got.digital_two = rsp_tdata[26];
            got.last        = rsp_tlast;
            got.pad         = rsp_tdata[31:27];
            if (channel_results_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected item: %s", $realtime, fmt_result(got));
               mismatch_count++;
            end else begin
               want = channel_results_q.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: expected %s", $realtime, fmt_result(want));
                     $display("%0t: got      %s", $realtime, fmt_result(got));
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   // byte driver, fed from the pending queue
   always @(negedge clock) begin
      logic [8:0] item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_accepted) begin
         // hold the current item until it is taken
      end else if (pending_bytes_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
         item = pending_bytes_q.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= item[8];
         req_tdata  <= item[7:0];
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result receiver with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic start);
      pending_bytes_q.push_back({start, data});
      bytes_queued++;
   endtask

   task automatic wait_idle();
      wait (bytes_accepted == bytes_queued);
      wait (channel_results_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [1:0] idx, input logic [RAW_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_thresholds(input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] mlo,
                                 input logic [RAW_W-1:0] mhi, input logic [RAW_W-1:0] hi);
      write_threshold(REG_EDGE_LOW, lo);
      write_threshold(REG_EDGE_MID_LOW, mlo);
      write_threshold(REG_EDGE_MID_HIGH, mhi);
      write_threshold(REG_EDGE_HIGH, hi);
   endtask

   // channel values: extremes, values next to a threshold, or anything
   function automatic logic [RAW_W-1:0] pick_channel();
      int sel;
      int v;
      sel = $urandom_range(9);
      if (sel == 0) return '0;
      if (sel == 1) return RAW_MAX;
      if (sel <= 4) begin
         case ($urandom_range(3))
            0: v = thresholds.low;
            1: v = thresholds.mid_low;
            2: v = thresholds.mid_high;
            default: v = thresholds.high;
         endcase
         v = v + $urandom_range(2) - 1;
         if (v < 0) v = 0;
         if (v > 2047) v = 2047;
         return RAW_W'(v);
      end
      return RAW_W'($urandom_range(2047));
   endfunction

   // one frame, mostly well formed; some cut short, some with trailing or stray bytes
   task automatic queue_random_frame();
      logic [175:0] packed_bits;
      int kind;
      int cut;
      kind = $urandom_range(19);
      if (kind == 0) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0);
      end
      for (int i = 0; i < 16; i++) packed_bits[11*i +: 11] = pick_channel();
      push_byte(8'($urandom_range(255)), 1'b1);
      cut = (kind == 1 || kind == 2) ? $urandom_range(0, 22) : 23;
      for (int k = 0; k < cut && k < 22; k++) push_byte(packed_bits[8*k +: 8], 1'b0);
      if (cut == 23) push_byte(8'($urandom_range(255)), 1'b0);
      if (kind == 3) begin
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   task automatic run_random(input int count);
      int start_count;
      start_count = bytes_queued;
      while (bytes_queued - start_count < count) queue_random_frame();
      wait_idle();
   endtask

   // stimulus sequence
   initial begin
      logic [175:0] packed_bits;
      logic [RAW_W-1:0] lo;
      logic [RAW_W-1:0] mlo;
      logic [RAW_W-1:0] mhi;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles often, receiver stalls more
      send_gap_pct = 23;
      recv_gap_pct = 61;

      // directed: stray byte while idle, header inside a frame, extreme channels
      push_byte(8'hA5, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'h00, 1'b1);
      for (int i = 0; i < 16; i++) packed_bits[11*i +: 11] = (i % 2 == 0) ? RAW_MAX : '0;
      for (int k = 0; k < 22; k++) push_byte(packed_bits[8*k +: 8], 1'b0);
      push_byte(8'h07, 1'b0);
      wait_idle();

      // ordered random thresholds
      lo  = RAW_W'($urandom_range(0, 700));
      mlo = lo + RAW_W'($urandom_range(0, 600));
      mhi = mlo + RAW_W'($urandom_range(0, 300));
      set_thresholds(lo, mlo, mhi, mhi + RAW_W'($urandom_range(0, 400)));
      run_random(120);

      // roles swapped
      send_gap_pct = 61;
      recv_gap_pct = 23;
      set_thresholds('0, '0, '0, '0);
      run_random(120);
      set_thresholds(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX);
      run_random(120);

      // no idling on either side, unordered thresholds
      send_gap_pct = 0;
      recv_gap_pct = 0;
      set_thresholds(11'd1500, 11'd200, RAW_MAX, '0);
      run_random(120);
      set_thresholds(RAW_W'($urandom_range(2047)), RAW_W'($urandom_range(2047)),
                     RAW_W'($urandom_range(2047)), RAW_W'($urandom_range(2047)));
      run_random(120);

      if (mismatch_count == 0) begin
         $display("sbus_channel_decoder_top: match");
      end else begin
         $display("sbus_channel_decoder_top: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("sbus_channel_decoder_top: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sbcd_pkg.sv
hdl/sbcd_front.sv
hdl/sbcd_queue.sv
hdl/sbcd_back.sv
hdl/sbus_channel_decoder_top.sv
tb/sv/tb_top.sv
